[sv/prts_pkg.sv]
// ----------------------------------------------------------------------------
// prts_pkg
// Shared types and constants for the streaming timestamp parser.
// ----------------------------------------------------------------------------
package prts_pkg;

	localparam int MaxFractionDigits = 9;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [63:0] epoch_nanos;
		logic [2:0]  status;
	} out_item_t;

	// fields handed from the character front end to the epoch back end
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [29:0] frac;
		logic        off_neg;
		logic [6:0]  off_hours;
		logic [6:0]  off_mins;
		logic [2:0]  status;
	} job_t;

	typedef enum logic [3:0] {
		PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_T, PH_HOUR, PH_COLON1,
		PH_MIN, PH_COLON2, PH_SEC, PH_AFTER_SEC, PH_FRAC, PH_OFFSET, PH_AFTER_Z,
		PH_DEAD
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_CIV, BK_DAYS, BK_SECS, BK_NANO, BK_NHI, BK_OFFS, BK_DONE
	} back_state_t;

	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StOff = 3'd1;
	localparam logic [2:0] StLong = 3'd2;
	localparam logic [2:0] StFrac = 3'd3;
	localparam logic [2:0] StDt = 3'd4;

	localparam logic [7:0] ChDash = 8'd45;
	localparam logic [7:0] ChPlus = 8'd43;
	localparam logic [7:0] ChDot = 8'd46;
	localparam logic [7:0] ChColon = 8'd58;
	localparam logic [7:0] ChT = 8'd84;
	localparam logic [7:0] ChZ = 8'd90;

	// weight of each fraction digit in nanoseconds
	function automatic logic [26:0] frac_weight(input logic [3:0] idx);
		case (idx)
			4'd0: frac_weight = 27'd100000000;
			4'd1: frac_weight = 27'd10000000;
			4'd2: frac_weight = 27'd1000000;
			4'd3: frac_weight = 27'd100000;
			4'd4: frac_weight = 27'd10000;
			4'd5: frac_weight = 27'd1000;
			4'd6: frac_weight = 27'd100;
			4'd7: frac_weight = 27'd10;
			4'd8: frac_weight = 27'd1;
			default: frac_weight = 27'd0;
		endcase
	endfunction

endpackage

[sv/prts_front.sv]
// ----------------------------------------------------------------------------
// prts_front
// Character scanner: accumulates the timestamp fields and emits one job per
// character marked last.
// ----------------------------------------------------------------------------
module prts_front #(
	parameter int MAX_FRACTION_DIGITS = prts_pkg::MaxFractionDigits
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  prts_pkg::in_item_t in_item,
	output logic              job_valid,
	output prts_pkg::job_t    job
);
	import prts_pkg::*;

	localparam logic [4:0] MaxFd = 5'(MAX_FRACTION_DIGITS);

	phase_t      phase_q, phase_d;
	logic [5:0]  pos_q, pos_d;
	logic [13:0] year_q, year_d;
	logic [6:0]  mon_q, mon_d, day_q, day_d, hour_q, hour_d;
	logic [6:0]  min_q, min_d, sec_q, sec_d;
	logic [29:0] frac_q, frac_d;
	logic [4:0]  fcnt_q, fcnt_d;
	logic        neg_q, neg_d;
	logic [6:0]  offh_q, offh_d, offm_q, offm_d;
	logic [3:0]  err_q, err_d;

	logic        dig;
	logic [3:0]  dv;
	logic [6:0]  two_acc;
	logic [6:0]  two_cur;
	logic        two_bad;
	logic [6:0]  two_lo, two_hi;
	logic [3:0]  ef;
	logic [2:0]  st;

	assign dig = (in_item.char_code >= 8'd48) && (in_item.char_code <= 8'd57);
	assign dv = 4'(in_item.char_code - 8'd48);

	// current two-digit field and its range
	always_comb begin
		two_cur = mon_q; two_lo = 7'd1; two_hi = 7'd12;
		case (phase_q)
			PH_DAY:  begin two_cur = day_q;  two_lo = 7'd1; two_hi = 7'd31; end
			PH_HOUR: begin two_cur = hour_q; two_lo = 7'd0; two_hi = 7'd23; end
			PH_MIN:  begin two_cur = min_q;  two_lo = 7'd0; two_hi = 7'd59; end
			PH_SEC:  begin two_cur = sec_q;  two_lo = 7'd0; two_hi = 7'd60; end
			default: ;
		endcase
		two_acc = 7'(two_cur * 7'd10 + 7'(dv));
		two_bad = (two_acc < two_lo) || (two_acc > two_hi);
	end

	// per-character state update
	always_comb begin
		phase_d = phase_q; pos_d = pos_q; year_d = year_q;
		mon_d = mon_q; day_d = day_q; hour_d = hour_q; min_d = min_q; sec_d = sec_q;
		frac_d = frac_q; fcnt_d = fcnt_q; neg_d = neg_q; offh_d = offh_q;
		offm_d = offm_q; err_d = err_q;
		unique case (phase_q)
			PH_YEAR: begin
				if (!dig) begin err_d[3] = 1'b1; phase_d = PH_DEAD; end
				else begin
					year_d = 14'(year_q * 14'd10 + 14'(dv));
					if (pos_q >= 6'd3) begin pos_d = '0; phase_d = PH_DASH1; end
					else pos_d = pos_q + 6'd1;
				end
			end
			PH_DASH1, PH_DASH2, PH_T, PH_COLON1, PH_COLON2: begin
				if (in_item.char_code == ((phase_q == PH_T) ? ChT :
					(phase_q == PH_DASH1 || phase_q == PH_DASH2) ? ChDash : ChColon))
					phase_d = phase_t'(phase_q + 4'd1);
				else begin err_d[3] = 1'b1; phase_d = PH_DEAD; end
			end
			PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC: begin
				if (!dig) begin err_d[3] = 1'b1; phase_d = PH_DEAD; end
				else begin
					case (phase_q)
						PH_MONTH: mon_d = two_acc;
						PH_DAY:   day_d = two_acc;
						PH_HOUR:  hour_d = two_acc;
						PH_MIN:   min_d = two_acc;
						default:  sec_d = two_acc;
					endcase
					if (pos_q >= 6'd1) begin
						pos_d = '0;
						if (two_bad) begin err_d[3] = 1'b1; phase_d = PH_DEAD; end
						else phase_d = phase_t'(phase_q + 4'd1);
					end else pos_d = pos_q + 6'd1;
				end
			end
			PH_AFTER_SEC, PH_FRAC: begin
				if (phase_q == PH_AFTER_SEC && in_item.char_code == ChDot)
					phase_d = PH_FRAC;
				else if (phase_q == PH_FRAC && dig) begin
					if (fcnt_q < 5'd9)
						frac_d = frac_q + 30'(dv) * 30'(frac_weight(fcnt_q[3:0]));
					if (fcnt_q < 5'd31) fcnt_d = fcnt_q + 5'd1;
					if (fcnt_d > MaxFd) err_d[1] = 1'b1;
				end else if (in_item.char_code == ChZ) phase_d = PH_AFTER_Z;
				else if (in_item.char_code == ChPlus || in_item.char_code == ChDash) begin
					neg_d = in_item.char_code == ChDash;
					phase_d = PH_OFFSET; pos_d = '0;
				end else if (phase_q == PH_FRAC) err_d[2] = 1'b1;
				else begin err_d[3] = 1'b1; phase_d = PH_DEAD; end
			end
			PH_OFFSET: begin
				if (pos_q == 6'd2) begin
					if (in_item.char_code != ChColon) err_d[0] = 1'b1;
				end else if (pos_q < 6'd5) begin
					if (!dig) err_d[0] = 1'b1;
					else if (pos_q < 6'd2) offh_d = 7'(offh_q * 7'd10 + 7'(dv));
					else offm_d = 7'(offm_q * 7'd10 + 7'(dv));
				end else err_d[0] = 1'b1;
				if (pos_q < 6'd6) pos_d = pos_q + 6'd1;
			end
			PH_AFTER_Z: err_d[0] = 1'b1;
			PH_DEAD: ;
			default: ;
		endcase
	end

	// final status on the last character
	always_comb begin
		ef = err_d;
		if (!err_d[3] && !(phase_d == PH_AFTER_Z || (phase_d == PH_OFFSET && pos_d == 6'd5)))
			ef[0] = 1'b1;
		if (ef[0]) st = StOff;
		else if (ef[1]) st = StLong;
		else if (ef[2]) st = StFrac;
		else if (ef[3]) st = StDt;
		else st = StOk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_YEAR; pos_q <= '0; year_q <= '0; mon_q <= '0; day_q <= '0;
			hour_q <= '0; min_q <= '0; sec_q <= '0; frac_q <= '0; fcnt_q <= '0;
			neg_q <= 1'b0; offh_q <= '0; offm_q <= '0; err_q <= '0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= in_valid && in_item.last_char;
			if (in_valid) begin
				if (in_item.last_char) begin
					phase_q <= PH_YEAR; pos_q <= '0; year_q <= '0; mon_q <= '0;
					day_q <= '0; hour_q <= '0; min_q <= '0; sec_q <= '0; frac_q <= '0;
					fcnt_q <= '0; neg_q <= 1'b0; offh_q <= '0; offm_q <= '0;
					err_q <= '0;
				end else begin
					phase_q <= phase_d; pos_q <= pos_d; year_q <= year_d;
					mon_q <= mon_d; day_q <= day_d; hour_q <= hour_d; min_q <= min_d;
					sec_q <= sec_d; frac_q <= frac_d; fcnt_q <= fcnt_d; neg_q <= neg_d;
					offh_q <= offh_d; offm_q <= offm_d; err_q <= err_d;
				end
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (in_valid && in_item.last_char) begin
			job <= '{year: year_d, month: mon_d, day: day_d, hour: hour_d, minute: min_d,
				second: sec_d, frac: frac_d, off_neg: neg_d, off_hours: offh_d,
				off_mins: offm_d, status: st};
		end
	end

endmodule

[sv/prts_queue.sv]
// ----------------------------------------------------------------------------
// prts_queue
// Small job queue between the scanner and the epoch unit.
// ----------------------------------------------------------------------------
module prts_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  prts_pkg::job_t wdata,
	output logic           almost_full,
	input  logic           rd,
	output logic           nonempty,
	output prts_pkg::job_t rdata
);
	import prts_pkg::*;

	localparam int AW = $clog2(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign nonempty = cnt_q != '0;
	// two slots kept back for the job in flight in the scanner register
	assign almost_full = cnt_q >= (AW+1)'(DEPTH - 2);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

endmodule

[sv/prts_back.sv]
// ----------------------------------------------------------------------------
// prts_back
// Epoch unit: civil date to days, then seconds, nanoseconds and offset, one
// step per state, with a one-entry result register.
// ----------------------------------------------------------------------------
module prts_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_avail,
	input  prts_pkg::job_t    job,
	output logic              job_take,
	output logic              empty,
	input  logic              pop,
	output prts_pkg::out_item_t result
);
	import prts_pkg::*;

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [4:0]  era_q;
	logic [8:0]  yoe_q;
	logic [9:0]  doy_q;
	logic [12:0] offmin_q;
	logic signed [23:0] days_q;
	logic signed [40:0] secs_q;
	logic [63:0] nanos_q;
	logic [63:0] res_nanos_q;
	logic [2:0]  res_status_q;
	logic        res_full_q;

	// days_from_civil on narrow values
	logic [14:0] yy;
	logic [27:0] era_prod;
	logic [4:0]  era;
	logic [8:0]  mstart;
	logic [1:0]  yoe_hund;
	logic [18:0] doe;
	logic [49:0] lo_prod;
	logic signed [50:0] hi_prod;
	logic [48:0] off_ns;

	// era by reciprocal multiply (exact for years up to 9999), month start table
	always_comb begin
		yy = 15'(job_q.year) + 15'd400 - ((job_q.month <= 7'd2) ? 15'd1 : 15'd0);
		era_prod = 28'(yy) * 28'd5243;
		era = era_prod[25:21];
		unique case (job_q.month)
			7'd1:  mstart = 9'd306;
			7'd2:  mstart = 9'd337;
			7'd3:  mstart = 9'd0;
			7'd4:  mstart = 9'd31;
			7'd5:  mstart = 9'd61;
			7'd6:  mstart = 9'd92;
			7'd7:  mstart = 9'd122;
			7'd8:  mstart = 9'd153;
			7'd9:  mstart = 9'd184;
			7'd10: mstart = 9'd214;
			7'd11: mstart = 9'd245;
			7'd12: mstart = 9'd275;
			default: mstart = 9'd0;
		endcase
	end

	// day of era, split seconds products and offset in nanoseconds
	always_comb begin
		yoe_hund = (yoe_q >= 9'd300) ? 2'd3 : (yoe_q >= 9'd200) ? 2'd2 :
			(yoe_q >= 9'd100) ? 2'd1 : 2'd0;
		doe = 19'(yoe_q) * 19'd365 + 19'(yoe_q >> 2) - 19'(yoe_hund) + 19'(doy_q);
		lo_prod = 50'(secs_q[19:0]) * 50'd1000000000;
		hi_prod = 51'($signed(secs_q[40:20])) * 51'sd1000000000;
		off_ns = 49'(offmin_q) * 49'd60000000000;
	end

	assign job_take = (state_q == BK_IDLE) && job_avail;
	assign empty = !res_full_q;
	assign result = '{epoch_nanos: res_nanos_q, status: res_status_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_avail) state_d = BK_CIV;
			BK_CIV:  state_d = BK_DAYS;
			BK_DAYS: state_d = BK_SECS;
			BK_SECS: state_d = BK_NANO;
			BK_NANO: state_d = BK_NHI;
			BK_NHI:  state_d = BK_OFFS;
			BK_OFFS: state_d = BK_DONE;
			BK_DONE: if (!res_full_q || pop) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath, one step per state
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: job_q <= job;
			BK_CIV: begin
				era_q <= era;
				yoe_q <= 9'(yy - 15'(era) * 15'd400);
				doy_q <= 10'(mstart) + 10'(job_q.day) - 10'd1;
				offmin_q <= 13'(job_q.off_hours) * 13'd60 + 13'(job_q.off_mins);
			end
			BK_DAYS: days_q <= 24'(era_q) * 24'sd146097 + 24'(doe) - 24'sd719468
				- 24'sd146097;
			BK_SECS: secs_q <= 41'(days_q) * 41'sd86400 + 41'(job_q.hour) * 41'sd3600
				+ 41'(job_q.minute) * 41'sd60 + 41'(job_q.second);
			BK_NANO: nanos_q <= 64'(lo_prod) + 64'(job_q.frac);
			BK_NHI:  nanos_q <= nanos_q + {hi_prod[43:0], 20'd0};
			BK_OFFS: nanos_q <= job_q.off_neg ? nanos_q + 64'(off_ns)
				: nanos_q - 64'(off_ns);
			default: ;
		endcase
		if (state_q == BK_DONE && (!res_full_q || pop)) begin
			res_nanos_q <= (job_q.status == StOk) ? nanos_q : '0;
			res_status_q <= job_q.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE; res_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_DONE && (!res_full_q || pop)) res_full_q <= 1'b1;
			else if (pop) res_full_q <= 1'b0;
		end
	end

endmodule

[sv/parse_rfc3339_timestamp_top.sv]
// ----------------------------------------------------------------------------
// parse_rfc3339_timestamp_top
// Streaming RFC 3339 timestamp parser giving UTC nanoseconds since 1970.
// ----------------------------------------------------------------------------
// Input: one character per transaction (push while full is low); last_char
// marks the final character of a timestamp. Each timestamp yields one result
// transaction (epoch_nanos, status) read while empty is low with pop.
// The scanner takes one character per cycle while full is low. Per timestamp
// the epoch unit steps through its states in order (take, civil fields, days,
// seconds, two half multiplies, offset, hand off) and takes no new job until it
// is back in its idle state, so short timestamps are limited by the epoch unit.
// A four-entry job queue decouples the two; full rises at two held jobs.
// If pop stays low the result register holds, then the queue fills and
// full stops input. Reset clears the scanner fields, the epoch unit's state and result flag, and empties the queue.
// ----------------------------------------------------------------------------
module parse_rfc3339_timestamp_top #(
	parameter int MAX_FRACTION_DIGITS = prts_pkg::MaxFractionDigits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  prts_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output prts_pkg::out_item_t out_item
);
	import prts_pkg::*;

	logic job_valid, job_avail, job_take;
	job_t job_f, job_b;

	prts_front #(.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)) u_front (
		.clk, .arst_n, .in_valid(push && !full), .in_item,
		.job_valid, .job(job_f)
	);

	prts_queue #(.DEPTH(4)) u_queue (
		.clk, .arst_n, .wr(job_valid), .wdata(job_f), .almost_full(full),
		.rd(job_take), .nonempty(job_avail), .rdata(job_b)
	);

	prts_back u_back (
		.clk, .arst_n, .job_avail, .job(job_b), .job_take,
		.empty, .pop, .result(out_item)
	);

endmodule

[tb/tb_parse_rfc3339_timestamp_checker.sv]
// ----------------------------------------------------------------------------
// tb_parse_rfc3339_timestamp_checker
// Watches both channels of the timestamp parser, predicts every result from
// the accepted characters and compares the whole item in arrival order.
// ----------------------------------------------------------------------------
module tb_parse_rfc3339_timestamp_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  prts_pkg::in_item_t  in_item,
	input  logic                empty,
	input  logic                pop,
	input  prts_pkg::out_item_t out_item,
	output int                  fail_count,
	output int                  pending_count
);
	import prts_pkg::*;

	localparam logic [3:0] ErrOff = 4'd1;
	localparam logic [3:0] ErrLong = 4'd2;
	localparam logic [3:0] ErrFrac = 4'd4;
	localparam logic [3:0] ErrDt = 4'd8;

	// parser state mirror
	phase_t      ph;
	logic [5:0]  dpos;
	logic [13:0] yr;
	logic [6:0]  mon, dy, hr, mn, sc, offh, offm;
	logic [29:0] frac;
	logic [4:0]  fcnt;
	logic        offneg;
	logic [3:0]  errs;

	out_item_t expected_results[$];

	assign pending_count = expected_results.size();

	function automatic bit is_dig(logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic longint civil_days(int y, int m, int d);
		longint yy, era, yoe, mp, doy, doe;
		yy = y - (m <= 2 ? 1 : 0) + 400;
		era = yy / 400;
		yoe = yy - era * 400;
		mp = (m + 9) % 12;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468 - 146097;
	endfunction

	task automatic clear_parse();
		ph = PH_YEAR; dpos = 0; yr = 0; mon = 0; dy = 0; hr = 0; mn = 0; sc = 0;
		frac = 0; fcnt = 0; offneg = 0; offh = 0; offm = 0; errs = 0;
	endtask

	task automatic dt_bad();
		errs |= ErrDt;
		ph = PH_DEAD;
	endtask

	task automatic field2(logic [7:0] c, ref logic [6:0] f, input int lo, input int hi);
		if (!is_dig(c)) begin
			dt_bad();
			return;
		end
		f = 7'(f * 10 + (c - 48));
		dpos++;
		if (dpos >= 2) begin
			dpos = 0;
			if (f < lo || f > hi) dt_bad();
			else ph = phase_t'(ph + 1);
		end
	endtask

	task automatic sep(logic [7:0] c, logic [7:0] want);
		if (c == want) ph = phase_t'(ph + 1);
		else dt_bad();
	endtask

	task automatic open_off(logic [7:0] c);
		if (c == ChZ) ph = PH_AFTER_Z;
		else begin
			offneg = (c == ChDash);
			ph = PH_OFFSET;
			dpos = 0;
		end
	endtask

	// advance the parse by one character, queue a result on the last one
	task automatic take_char(in_item_t it);
		logic [7:0] c;
		logic [2:0] st;
		longint secs;
		logic [63:0] ns, offns;
		out_item_t r;
		c = it.char_code;
		case (ph)
			PH_YEAR: begin
				if (!is_dig(c)) dt_bad();
				else begin
					yr = 14'(yr * 10 + (c - 48));
					dpos++;
					if (dpos >= 4) begin
						dpos = 0;
						ph = PH_DASH1;
					end
				end
			end
			PH_DASH1, PH_DASH2: sep(c, ChDash);
			PH_MONTH: field2(c, mon, 1, 12);
			PH_DAY: field2(c, dy, 1, 31);
			PH_T: sep(c, ChT);
			PH_HOUR: field2(c, hr, 0, 23);
			PH_COLON1, PH_COLON2: sep(c, ChColon);
			PH_MIN: field2(c, mn, 0, 59);
			PH_SEC: field2(c, sc, 0, 60);
			PH_AFTER_SEC: begin
				if (c == ChDot) ph = PH_FRAC;
				else if (c == ChZ || c == ChPlus || c == ChDash) open_off(c);
				else dt_bad();
			end
			PH_FRAC: begin
				if (is_dig(c)) begin
					if (fcnt < 9) frac += 30'((c - 48) * (10 ** (8 - fcnt)));
					if (fcnt < 31) fcnt++;
					if (fcnt > MaxFractionDigits) errs |= ErrLong;
				end else if (c == ChZ || c == ChPlus || c == ChDash) open_off(c);
				else errs |= ErrFrac;
			end
			PH_OFFSET: begin
				if (dpos == 2) begin
					if (c != ChColon) errs |= ErrOff;
				end else if (dpos < 5) begin
					if (!is_dig(c)) errs |= ErrOff;
					else if (dpos < 2) offh = 7'(offh * 10 + (c - 48));
					else offm = 7'(offm * 10 + (c - 48));
				end else errs |= ErrOff;
				if (dpos < 6) dpos++;
			end
			PH_AFTER_Z: errs |= ErrOff;
			default: ;
		endcase
		if (!it.last_char) return;
		if (!(errs & ErrDt) && !(ph == PH_AFTER_Z || (ph == PH_OFFSET && dpos == 5)))
			errs |= ErrOff;
		if (errs & ErrOff) st = StOff;
		else if (errs & ErrLong) st = StLong;
		else if (errs & ErrFrac) st = StFrac;
		else if (errs & ErrDt) st = StDt;
		else st = StOk;
		ns = 0;
		if (st == StOk) begin
			secs = civil_days(yr, mon, dy) * 86400 + hr * 3600 + mn * 60 + sc;
			offns = (64'(offh) * 60 + offm) * 64'd60000000000;
			ns = 64'(secs) * 64'd1000000000 + frac;
			if (offneg) ns += offns;
			else ns -= offns;
		end
		r.epoch_nanos = ns;
		r.status = st;
		expected_results = {expected_results, r};
		clear_parse();
	endtask

	// sample both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			clear_parse();
			expected_results.delete();
			fail_count <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction: nanos=%0d status=%0d",
							out_item.epoch_nanos, out_item.status);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (out_item !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected nanos=%0d status=%0d, got nanos=%0d status=%0d",
								want.epoch_nanos, want.status,
								out_item.epoch_nanos, out_item.status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (push && !full) take_char(in_item);
		end
	end

endmodule

[tb/tb_parse_rfc3339_timestamp_top.sv]
// ----------------------------------------------------------------------------
// tb_parse_rfc3339_timestamp_top
// Feeds well-formed, damaged and noisy timestamps into the parser with random
// gaps and stalls on both sides; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_parse_rfc3339_timestamp_top;
	import prts_pkg::*;

	localparam int StallLimit = 5000;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  in_item;
	logic      empty;
	logic      pop;
	out_item_t out_item;
	int        fail_count;
	int        pending_count;
	int        chars_sent;
	int        idle_cycles;
	bit        quiet_phase;
	bit        hold_results;

	parse_rfc3339_timestamp_top u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

	tb_parse_rfc3339_timestamp_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// one character transaction, with an optional random gap first
	task automatic send_char(logic [7:0] c, logic lastc);
		int gap;
		if (!quiet_phase && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item.char_code <= c;
		in_item.last_char <= lastc;
		do @(posedge clk); while (full);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_char(s[i], i == s.len() - 1);
	endtask

	function automatic string two_dig(int v);
		return $sformatf("%02d", v);
	endfunction

	// random timestamp text, mostly well formed, sometimes damaged
	function automatic string make_stamp();
		string s, fr;
		int nf, pos;
		s = {$sformatf("%04d", $urandom_range(0, 9999)), "-",
			two_dig($urandom_range(1, 12)), "-", two_dig($urandom_range(1, 31)), "T",
			two_dig($urandom_range(0, 23)), ":", two_dig($urandom_range(0, 59)), ":",
			two_dig($urandom_range(0, 60))};
		if ($urandom_range(0, 1)) begin
			nf = $urandom_range(0, 3) == 0 ? $urandom_range(10, 13) : $urandom_range(0, 9);
			fr = ".";
			repeat (nf) fr = {fr, string'(8'($urandom_range(48, 57)))};
			s = {s, fr};
		end
		case ($urandom_range(0, 2))
			0: s = {s, "Z"};
			1: s = {s, "+", two_dig($urandom_range(0, 99)), ":", two_dig($urandom_range(0, 99))};
			default: s = {s, "-", two_dig($urandom_range(0, 99)), ":", two_dig($urandom_range(0, 99))};
		endcase
		// damage: random character replaced, or text cut short, or extended
		case ($urandom_range(0, 9))
			0: begin
				pos = $urandom_range(0, s.len() - 1);
				s[pos] = 8'($urandom_range(0, 255));
			end
			1: s = s.substr(0, $urandom_range(0, s.len() - 2));
			2: s = {s, string'(8'($urandom_range(0, 255)))};
			default: ;
		endcase
		return s;
	endfunction

	// result side: random stall bursts, one long hold-off on request
	initial begin
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
				hold_results = 0;
			end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				stall = $urandom_range(1, 11);
				repeat (stall) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		string noise;
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		chars_sent = 0;
		quiet_phase = 0;
		hold_results = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every status, normalisation, offsets
		send_text("1970-01-01T00:00:00Z");
		send_text("9999-12-31T23:59:60.999999999Z");
		send_text("0000-01-01T00:00:00Z");
		send_text("2000-02-31T12:30:45.5+05:30");
		send_text("2024-06-15T08:00:00-99:99");
		send_text("2024-06-15T08:00:00.1234567891Z");
		send_text("2024-06-15T08:00:00.12x4Z");
		send_text("2024-13-15T08:00:00Z");
		send_text("2024-06-15T24:00:00Z");
		send_text("2024-06-15t08:00:00Z");
		send_text("2024-06-15T08:00:00");
		send_text("2024-06-15T08:00:00+05");
		send_text("2024-06-15T08:00:00+05;30");
		send_text("2024-06-15T08:00:00ZZ");
		send_text("2024-06-15T08:00:00+01:00+");
		send_text("2024-06-15T08:00:00.Z");
		send_text("2024-06-15T08:00:00x");
		send_text("2024-00-00T00:61:61Z");
		send_char(8'hff, 1'b1);
		send_char(8'h00, 1'b1);
		send_text("2024-06-15T08:00:00.12x4567891234-00:01");

		// let everything drain, then force back-pressure with a long hold
		push <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		hold_results = 1;
		repeat (8) send_text(make_stamp());

		// random part
		while (chars_sent < 1900) begin
			if (chars_sent > 1700) quiet_phase = 1;
			if ($urandom_range(0, 15) == 0) begin
				noise = "";
				repeat ($urandom_range(1, 5)) noise = {noise, string'(8'($urandom_range(0, 255)))};
				send_text(noise);
			end else send_text(make_stamp());
		end
		push <= 1'b0;
		@(posedge clk);

		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
